/* rtl/dssg_pkg.sv */
// Types and constants shared by the diagnostic session and security gate.
package dssg_pkg;

  typedef enum logic [1:0] {
    OUT_POS = 2'd0,
    OUT_NEG = 2'd1,
    OUT_FWD = 2'd2
  } outcome_e;

  typedef enum logic [3:0] {
    RSN_NONE     = 4'd0,
    RSN_UNKNOWN  = 4'd1,
    RSN_SESSION  = 4'd2,
    RSN_LOCKED   = 4'd3,
    RSN_LENGTH   = 4'd4,
    RSN_SUBFUNC  = 4'd5,
    RSN_BAD_KEY  = 4'd6,
    RSN_LOCKOUT  = 4'd7,
    RSN_SEQUENCE = 4'd8
  } reason_e;

  typedef enum logic [1:0] {
    SEC_LOCKED   = 2'd0,
    SEC_SEEDSENT = 2'd1,
    SEC_UNLOCKED = 2'd2,
    SEC_LOCKOUT  = 2'd3
  } sec_e;

  typedef enum logic [1:0] {
    SESS_DEFAULT = 2'd0,
    SESS_PROG    = 2'd1,
    SESS_EXT     = 2'd2
  } session_e;

  typedef enum logic [1:0] {
    CFG_MAX_ATTEMPTS = 2'd0,
    CFG_LOCKOUT      = 2'd1,
    CFG_KEY_MASK     = 2'd2
  } cfg_idx_e;

  localparam logic [7:0] SID_SESSION  = 8'h10;
  localparam logic [7:0] SID_RESET    = 8'h11;
  localparam logic [7:0] SID_CLR_DTC  = 8'h14;
  localparam logic [7:0] SID_RD_DTC   = 8'h19;
  localparam logic [7:0] SID_RD_DID   = 8'h22;
  localparam logic [7:0] SID_SECURITY = 8'h27;
  localparam logic [7:0] SID_WR_DID   = 8'h2E;
  localparam logic [7:0] SID_TESTER   = 8'h3E;

  localparam logic [7:0] NEG_RSP_ID   = 8'h7F;
  localparam logic [7:0] POS_RSP_BIT  = 8'h40;
  localparam logic [7:0] SUPPRESS_BIT = 8'h80;

  localparam logic [7:0] SF_REQ_SEED  = 8'h01;
  localparam logic [7:0] SF_SEND_KEY  = 8'h02;

  // session mask bits
  localparam logic [2:0] MSK_DEF  = 3'b001;
  localparam logic [2:0] MSK_PROG = 3'b010;
  localparam logic [2:0] MSK_EXT  = 3'b100;
  localparam logic [2:0] MSK_ALL  = 3'b111;

  localparam logic [3:0]  MAX_ATTEMPTS_RST = 4'd3;
  localparam logic [13:0] LOCKOUT_RST      = 14'd10000;
  localparam logic [31:0] KEY_MASK_RST     = 32'hA5A5A5A5;
  localparam logic [3:0]  FAILED_MAX       = 4'd15;
  localparam logic [11:0] KEY_REQ_LEN      = 12'd6;

  typedef struct packed {
    logic        kind;
    logic [7:0]  service_id;
    logic [7:0]  sub_function;
    logic [31:0] key_value;
    logic [11:0] request_length;
    logic [31:0] fresh_seed;
  } req_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [7:0]  response_id;
    logic [3:0]  reason;
    logic [7:0]  echo_byte;
    logic [31:0] seed_out;
    logic [1:0]  session_now;
    logic        unlocked;
  } rsp_t;

  typedef struct packed {
    session_e    session;
    sec_e        security;
    logic [31:0] held_seed;
    logic [3:0]  failed;
  } gate_state_t;

  typedef struct packed {
    logic [3:0]  max_attempts;
    logic [31:0] key_mask;
  } gate_cfg_t;

endpackage

/* rtl/diag_service_session_security_gate.sv */
// Diagnostic session and security gate, top level.
// An accepted request waits in the input register until the result side is free; its result is then registered.
// Throughput: one request or tick per cycle; the only stall comes from the result side.
// Session, security state, seed, attempt count and lockout count update as a
// request leaves the input register, so the next request sees them at once.
// Reset clears all state to default session, locked, and loads register defaults.
module diag_service_session_security_gate #(
  parameter int unsigned LOCKOUT_COUNT_BITS = 14
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  dssg_pkg::req_t  in_req_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output dssg_pkg::rsp_t  out_rsp_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [31:0]     cfg_wdata_i
);
  import dssg_pkg::*;

  localparam int unsigned TickW = 14;
  localparam int unsigned CmpW  = (LOCKOUT_COUNT_BITS > TickW) ? LOCKOUT_COUNT_BITS : TickW;

  logic                          s1_valid_q;
  req_t                          s1_req_q;
  logic                          out_valid_q;
  rsp_t                          out_q;
  gate_state_t                   st_q, st_d;
  logic [LOCKOUT_COUNT_BITS-1:0] lock_q, lock_d;
  logic [3:0]                    max_attempts_q;
  logic [TickW-1:0]              lockout_ticks_q;
  logic [31:0]                   key_mask_q;
  gate_cfg_t                     cfg;
  logic [CmpW-1:0]               ticks_ext;
  logic [CmpW-1:0]               count_top;
  logic [LOCKOUT_COUNT_BITS-1:0] lock_load;
  logic                          out_free;
  logic                          proc;
  logic                          has_rsp;
  rsp_t                          rsp;

  assign ticks_ext = CmpW'(lockout_ticks_q);
  assign count_top = CmpW'({LOCKOUT_COUNT_BITS{1'b1}});
  assign lock_load = LOCKOUT_COUNT_BITS'((ticks_ext > count_top) ? count_top : ticks_ext);

  assign cfg.max_attempts = max_attempts_q;
  assign cfg.key_mask     = key_mask_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;

  dssg_eval #(
    .LockoutCountBits(LOCKOUT_COUNT_BITS)
  ) u_eval (
    .req_i      (s1_req_q),
    .st_i       (st_q),
    .lock_i     (lock_q),
    .cfg_i      (cfg),
    .lock_load_i(lock_load),
    .st_o       (st_d),
    .lock_o     (lock_d),
    .has_rsp_o  (has_rsp),
    .rsp_o      (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_attempts_q  <= MAX_ATTEMPTS_RST;
      lockout_ticks_q <= LOCKOUT_RST;
      key_mask_q      <= KEY_MASK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_ATTEMPTS: max_attempts_q  <= cfg_wdata_i[3:0];
        CFG_LOCKOUT:      lockout_ticks_q <= cfg_wdata_i[TickW-1:0];
        CFG_KEY_MASK:     key_mask_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.session   <= SESS_DEFAULT;
      st_q.security  <= SEC_LOCKED;
      st_q.held_seed <= '0;
      st_q.failed    <= '0;
      lock_q         <= '0;
    end else if (proc) begin
      st_q   <= st_d;
      lock_q <= lock_d;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_req_q <= in_req_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= proc && has_rsp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && has_rsp) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

/* rtl/dssg_eval.sv */
// Request decode, session and security gating, and next-state logic.
module dssg_eval #(
  parameter int unsigned LockoutCountBits = 14
) (
  input  dssg_pkg::req_t          req_i,
  input  dssg_pkg::gate_state_t   st_i,
  input  logic [LockoutCountBits-1:0] lock_i,
  input  dssg_pkg::gate_cfg_t     cfg_i,
  input  logic [LockoutCountBits-1:0] lock_load_i,
  output dssg_pkg::gate_state_t   st_o,
  output logic [LockoutCountBits-1:0] lock_o,
  output logic                    has_rsp_o,
  output dssg_pkg::rsp_t          rsp_o
);
  import dssg_pkg::*;

  logic        known;
  logic        fwd;
  logic        secreq;
  logic [2:0]  mask;
  logic [2:0]  minlen;
  logic [2:0]  sflag;
  logic [6:0]  sf_low;
  logic [7:0]  pos_id;
  logic [3:0]  failed_inc;
  logic [11:0] len;

  always_comb begin
    len    = req_i.request_length;
    sf_low = req_i.sub_function[6:0];
    pos_id = req_i.service_id | POS_RSP_BIT;
    failed_inc = (st_i.failed == FAILED_MAX) ? FAILED_MAX : st_i.failed + 4'd1;

    known  = 1'b1;
    fwd    = 1'b0;
    secreq = 1'b0;
    mask   = MSK_ALL;
    minlen = 3'd2;
    unique case (req_i.service_id)
      SID_SESSION:  begin mask = MSK_ALL; minlen = 3'd2; end
      SID_RESET:    begin mask = MSK_ALL; minlen = 3'd2; end
      SID_SECURITY: begin mask = MSK_EXT | MSK_PROG; minlen = 3'd2; end
      SID_TESTER:   begin mask = MSK_ALL; minlen = 3'd1; end
      SID_RD_DID:   begin mask = MSK_ALL; minlen = 3'd3; fwd = 1'b1; end
      SID_WR_DID: begin
        mask = MSK_EXT | MSK_PROG; minlen = 3'd4; fwd = 1'b1; secreq = 1'b1;
      end
      SID_CLR_DTC:  begin mask = MSK_ALL; minlen = 3'd4; fwd = 1'b1; end
      SID_RD_DTC:   begin mask = MSK_ALL; minlen = 3'd3; fwd = 1'b1; end
      default:      known = 1'b0;
    endcase

    unique case (st_i.session)
      SESS_DEFAULT: sflag = MSK_DEF;
      SESS_PROG:    sflag = MSK_PROG;
      SESS_EXT:     sflag = MSK_EXT;
      default:      sflag = 3'b000;
    endcase

    st_o      = st_i;
    lock_o    = lock_i;
    has_rsp_o = 1'b0;
    rsp_o     = '0;

    if (req_i.kind) begin
      if (st_i.security == SEC_LOCKOUT) begin
        if (lock_i != '0) begin
          lock_o = lock_i - LockoutCountBits'(1);
        end else begin
          st_o.security = SEC_LOCKED;
          st_o.failed   = '0;
          lock_o        = '0;
        end
      end
    end else if (len != '0) begin
      has_rsp_o         = 1'b1;
      rsp_o.outcome     = OUT_NEG;
      rsp_o.response_id = NEG_RSP_ID;
      priority if (!known) begin
        rsp_o.reason = RSN_UNKNOWN;
      end else if ((mask & sflag) == '0) begin
        rsp_o.reason = RSN_SESSION;
      end else if (secreq && st_i.security != SEC_UNLOCKED) begin
        rsp_o.reason = RSN_LOCKED;
      end else if (len < 12'(minlen)) begin
        rsp_o.reason = RSN_LENGTH;
      end else if (fwd) begin
        rsp_o.outcome     = OUT_FWD;
        rsp_o.response_id = req_i.service_id;
      end else if (req_i.service_id == SID_SESSION) begin
        if (sf_low < 7'd1 || sf_low > 7'd3) begin
          rsp_o.reason = RSN_SUBFUNC;
        end else begin
          st_o.session = session_e'(2'(sf_low - 7'd1));
          if (sf_low == 7'd1) begin
            st_o.security = SEC_LOCKED;
            st_o.failed   = '0;
            lock_o        = '0;
          end
          rsp_o.outcome     = OUT_POS;
          rsp_o.response_id = pos_id;
          rsp_o.echo_byte   = {1'b0, sf_low};
        end
      end else if (req_i.service_id == SID_RESET) begin
        if (req_i.sub_function < 8'd1 || req_i.sub_function > 8'd3) begin
          rsp_o.reason = RSN_SUBFUNC;
        end else begin
          st_o.session      = SESS_DEFAULT;
          st_o.security     = SEC_LOCKED;
          lock_o            = '0;
          rsp_o.outcome     = OUT_POS;
          rsp_o.response_id = pos_id;
          rsp_o.echo_byte   = req_i.sub_function;
        end
      end else if (req_i.service_id == SID_SECURITY) begin
        priority if (st_i.security == SEC_LOCKOUT) begin
          rsp_o.reason = RSN_LOCKOUT;
        end else if (req_i.sub_function == SF_REQ_SEED) begin
          rsp_o.outcome     = OUT_POS;
          rsp_o.response_id = pos_id;
          rsp_o.echo_byte   = req_i.sub_function;
          if (st_i.security != SEC_UNLOCKED) begin
            st_o.held_seed = req_i.fresh_seed;
            st_o.security  = SEC_SEEDSENT;
            rsp_o.seed_out = req_i.fresh_seed;
          end
        end else if (req_i.sub_function == SF_SEND_KEY) begin
          priority if (st_i.security != SEC_SEEDSENT) begin
            rsp_o.reason = RSN_SEQUENCE;
          end else if (len < KEY_REQ_LEN) begin
            rsp_o.reason = RSN_LENGTH;
          end else if (req_i.key_value == (~st_i.held_seed ^ cfg_i.key_mask)) begin
            st_o.security     = SEC_UNLOCKED;
            st_o.failed       = '0;
            rsp_o.outcome     = OUT_POS;
            rsp_o.response_id = pos_id;
            rsp_o.echo_byte   = req_i.sub_function;
          end else begin
            st_o.failed = failed_inc;
            if (failed_inc >= cfg_i.max_attempts) begin
              st_o.security = SEC_LOCKOUT;
              lock_o        = lock_load_i;
            end
            rsp_o.reason = RSN_BAD_KEY;
          end
        end else begin
          rsp_o.reason = RSN_SUBFUNC;
        end
      end else begin
        if (len >= 12'd2 && (req_i.sub_function & SUPPRESS_BIT) != '0) begin
          has_rsp_o = 1'b0;
        end
        rsp_o.outcome     = OUT_POS;
        rsp_o.response_id = pos_id;
        rsp_o.echo_byte   = (len >= 12'd2) ? {1'b0, sf_low} : 8'd0;
      end
    end

    rsp_o.session_now = st_o.session;
    rsp_o.unlocked    = (st_o.security == SEC_UNLOCKED);
  end

endmodule
